@@ rtl/cpe_pkg.sv @@
// Package for the cluster power estimator: shared widths, register map and
// pipeline word types. No dependencies.
package cpe_pkg;

  localparam int REG_W  = 16;
  localparam int F_W    = 17;   // frequency in half-MHz units
  localparam int A_W    = 18;   // multiplicand (power scale)
  localparam int B_W    = 20;   // multiplier (frequency term)
  localparam int NUM_W  = 37;   // dividend width
  localparam int DEN_W  = 21;   // divisor width
  localparam int OUT_W  = 17;
  localparam logic [OUT_W-1:0] OUT_MAX = 17'h1FFFF;

  localparam logic [2:0] REG_TYP_FREQ  = 3'd0;
  localparam logic [2:0] REG_TYP_POWER = 3'd1;
  localparam logic [2:0] REG_FREE_FREQ = 3'd2;
  localparam logic [2:0] REG_SWEET_FREQ = 3'd3;
  localparam logic [2:0] REG_PLAIN_FREQ = 3'd4;

  typedef struct packed {
    logic [REG_W-1:0] typ_freq;
    logic [REG_W-1:0] typ_power;
    logic [REG_W-1:0] free_freq;
    logic [REG_W-1:0] sweet_freq;
    logic [REG_W-1:0] plain_freq;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [REG_W-1:0] addend;
  } div_word_t;

endpackage

@@ rtl/cpe_front.sv @@
// Front stages: clamp, region select with operand build, then multiply.
// Depends on cpe_pkg.
module cpe_front #(
  parameter int FREQ_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cpe_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  input  logic [cpe_pkg::REG_W-1:0] in_freq,
  output cpe_pkg::div_word_t        out_w
);
  import cpe_pkg::*;

  localparam logic [REG_W-1:0] FMASK =
    (FREQ_WIDTH >= REG_W) ? {REG_W{1'b1}} : REG_W'((32'd1 << FREQ_WIDTH) - 32'd1);

  logic [F_W-1:0] tf, fr, sw, pl, f_in;
  logic [F_W:0]   lim;
  logic [F_W-1:0] p;

  assign tf   = {1'b0, cfg.typ_freq & FMASK};
  assign p    = {1'b0, cfg.typ_power};
  assign fr   = {cfg.free_freq & FMASK, 1'b0};
  assign sw   = {cfg.sweet_freq & FMASK, 1'b0};
  assign pl   = {cfg.plain_freq & FMASK, 1'b0};
  assign f_in = {in_freq & FMASK, 1'b0};
  assign lim  = {1'b0, tf} + {tf, 1'b0};

  // stage 1: clamp
  logic           v1_r;
  logic           z1_r;
  logic [F_W-1:0] f1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    z1_r <= (f_in == '0) || (tf == '0);
    f1_r <= ({1'b0, f_in} > lim) ? lim[F_W-1:0] : f_in;
  end

  // stage 2: region select
  logic [A_W-1:0]   a_nxt;
  logic [B_W-1:0]   b_nxt;
  logic [DEN_W-1:0] den_nxt;
  logic [REG_W-1:0] add_nxt;
  logic [F_W-1:0]   d_ramp, d_up;

  assign d_ramp = sw - fr;
  assign d_up   = pl - sw;

  always_comb begin
    a_nxt   = '0;
    b_nxt   = '0;
    den_nxt = DEN_W'(1);
    add_nxt = '0;
    if (z1_r) begin
      a_nxt = '0;
    end else if (f1_r > pl) begin
      a_nxt   = A_W'(p);
      b_nxt   = B_W'(f1_r - pl);
      den_nxt = DEN_W'({tf, 2'b00});
      add_nxt = cfg.typ_power;
    end else if (f1_r > sw) begin
      a_nxt   = A_W'({p, 1'b0});
      b_nxt   = B_W'({d_up, 1'b0}) + B_W'(d_up) + B_W'({f1_r - sw, 1'b0});
      den_nxt = DEN_W'({d_up, 3'b000}) + DEN_W'({d_up, 1'b0});
    end else if (f1_r >= fr) begin
      a_nxt = A_W'({p, 1'b0}) + A_W'(p);
      if (d_ramp == '0) begin
        b_nxt   = B_W'(1);
        den_nxt = DEN_W'(10);
      end else begin
        b_nxt   = B_W'(d_ramp) + B_W'(f1_r - fr);
        den_nxt = DEN_W'({d_ramp, 3'b000}) + DEN_W'({d_ramp, 1'b0});
      end
    end else begin
      a_nxt   = A_W'({p, 1'b0}) + A_W'(p);
      b_nxt   = B_W'(f1_r);
      den_nxt = DEN_W'({fr, 3'b000}) + DEN_W'({fr, 1'b0});
    end
  end

  logic             v2_r;
  logic [A_W-1:0]   a2_r;
  logic [B_W-1:0]   b2_r;
  logic [DEN_W-1:0] den2_r;
  logic [REG_W-1:0] add2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    a2_r   <= a_nxt;
    b2_r   <= b_nxt;
    den2_r <= den_nxt;
    add2_r <= add_nxt;
  end

  // stage 3: multiply
  logic [A_W+B_W-1:0] prod;
  assign prod = a2_r * b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_w.valid <= 1'b0;
    end else begin
      out_w.valid <= v2_r;
    end
    out_w.num    <= prod[NUM_W-1:0];
    out_w.den    <= den2_r;
    out_w.addend <= add2_r;
  end

endmodule

@@ rtl/cpe_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on cpe_pkg.
module cpe_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cpe_pkg::div_word_t        in_w,
  output logic                      out_valid,
  output logic [cpe_pkg::NUM_W-1:0] out_quot,
  output logic [cpe_pkg::REG_W-1:0] out_addend
);
  import cpe_pkg::*;

  logic             vld_r [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] nq_r  [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  logic [REG_W-1:0] add_r [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic             vld_in;
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] den_in;
    logic [REG_W-1:0] add_in;
    logic [DEN_W:0]   sh;
    logic             ge;

    if (i == 0) begin : g_first
      assign vld_in = in_w.valid;
      assign rem_in = '0;
      assign nq_in  = in_w.num;
      assign den_in = in_w.den;
      assign add_in = in_w.addend;
    end else begin : g_next
      assign vld_in = vld_r[i-1];
      assign rem_in = rem_r[i-1];
      assign nq_in  = nq_r[i-1];
      assign den_in = den_r[i-1];
      assign add_in = add_r[i-1];
    end

    assign sh = {rem_in, nq_in[NUM_W-1]};
    assign ge = sh >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      rem_r[i] <= ge ? DEN_W'(sh - {1'b0, den_in}) : sh[DEN_W-1:0];
      nq_r[i]  <= {nq_in[NUM_W-2:0], ge};
      den_r[i] <= den_in;
      add_r[i] <= add_in;
    end
  end

  assign out_valid  = vld_r[NUM_W-1];
  assign out_quot   = nq_r[NUM_W-1];
  assign out_addend = add_r[NUM_W-1];

endmodule

@@ rtl/cluster_power_estimator.sv @@
// Cluster power estimator top level: APB register file, front stages,
// pipelined divider and output stage. Depends on cpe_pkg, cpe_front, cpe_div.
//
// Usage:
//   Input channel: pulse start with in_freq (MHz); busy is always low, so a
//   new word may be started in every cycle.
//   Result channel: out_valid strobes for one cycle with out_power (mW).
//   The path from start to out_valid runs through clamp, region select and
//   multiply (three stages), the divider with one stage per quotient bit (37),
//   and the add/saturate output register.
//   Throughput is one word per cycle.
//   Registers are written over APB at byte address 4*index; reads return the
//   stored value. Write them only while no word is in flight.
//   Reset (rst_n low, synchronous) restores register defaults and drops all
//   words in flight. The receiver cannot stall; each result is presented for
//   exactly one cycle.
module cluster_power_estimator #(
  parameter int FREQ_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [cpe_pkg::REG_W-1:0] in_freq,
  output logic                      out_valid,
  output logic [cpe_pkg::OUT_W-1:0] out_power,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [4:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import cpe_pkg::*;

  localparam int LAT = NUM_W + 4;

  cfg_t cfg_r;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.typ_freq   <= 16'd2000;
      cfg_r.typ_power  <= 16'd1000;
      cfg_r.free_freq  <= 16'd500;
      cfg_r.sweet_freq <= 16'd1000;
      cfg_r.plain_freq <= 16'd1800;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_TYP_FREQ:   cfg_r.typ_freq   <= pwdata[REG_W-1:0];
        REG_TYP_POWER:  cfg_r.typ_power  <= pwdata[REG_W-1:0];
        REG_FREE_FREQ:  cfg_r.free_freq  <= pwdata[REG_W-1:0];
        REG_SWEET_FREQ: cfg_r.sweet_freq <= pwdata[REG_W-1:0];
        REG_PLAIN_FREQ: cfg_r.plain_freq <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TYP_FREQ:   prdata = {16'd0, cfg_r.typ_freq};
      REG_TYP_POWER:  prdata = {16'd0, cfg_r.typ_power};
      REG_FREE_FREQ:  prdata = {16'd0, cfg_r.free_freq};
      REG_SWEET_FREQ: prdata = {16'd0, cfg_r.sweet_freq};
      REG_PLAIN_FREQ: prdata = {16'd0, cfg_r.plain_freq};
      default:        prdata = '0;
    endcase
  end

  div_word_t        dw;
  logic             dv;
  logic [NUM_W-1:0] dq;
  logic [REG_W-1:0] dadd;

  cpe_front #(.FREQ_WIDTH(FREQ_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (start && !busy),
    .in_freq  (in_freq),
    .out_w    (dw)
  );

  cpe_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_w       (dw),
    .out_valid  (dv),
    .out_quot   (dq),
    .out_addend (dadd)
  );

  logic [NUM_W:0]   sum;
  logic [OUT_W-1:0] power_nxt;
  logic             valid_r;
  logic [OUT_W-1:0] power_r;

  assign sum       = {1'b0, dq} + (NUM_W+1)'(dadd);
  assign power_nxt = (sum > (NUM_W+1)'(OUT_MAX)) ? OUT_MAX : sum[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= dv;
    end
    power_r <= power_nxt;
  end

  assign out_valid = valid_r;
  assign out_power = power_r;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching start");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_freq == '0, LAT)) |-> (out_power == '0))
    else $error("zero frequency gave nonzero power");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule
